/* rtl/core/pwjd_pkg.sv */
// shared types and constants for the pulse-width joystick decoder
package pwjd_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CENTER_W    = 15;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_THR  = 2'd3;

  localparam logic [CENTER_W-1:0] Y_CENTER_RST  = 15'd195;
  localparam logic [CENTER_W-1:0] X_CENTER_RST  = 15'd185;
  localparam logic [CENTER_W-1:0] DEAD_ZONE_RST = 15'd40;
  localparam logic [THRESH_W-1:0] MODE_THR_RST  = 16'd1000;

  typedef enum logic [3:0] {
    DIR_STOP       = 4'd0,
    DIR_FWD_RIGHT  = 4'd1,
    DIR_FWD_LEFT   = 4'd2,
    DIR_BACK_RIGHT = 4'd3,
    DIR_BACK_LEFT  = 4'd4,
    DIR_FWD        = 4'd5,
    DIR_BACK       = 4'd6,
    DIR_RIGHT      = 4'd7,
    DIR_LEFT       = 4'd8
  } dir_e;

  // motor drive patterns: bit0 l rev, bit1 r rev, bit2 l fwd, bit3 r fwd
  localparam logic [3:0] DRV_STOP       = 4'd0;
  localparam logic [3:0] DRV_FWD_RIGHT  = 4'd4;
  localparam logic [3:0] DRV_FWD_LEFT   = 4'd8;
  localparam logic [3:0] DRV_BACK_RIGHT = 4'd1;
  localparam logic [3:0] DRV_BACK_LEFT  = 4'd2;
  localparam logic [3:0] DRV_FWD        = 4'd12;
  localparam logic [3:0] DRV_BACK       = 4'd3;
  localparam logic [3:0] DRV_RIGHT      = 4'd6;
  localparam logic [3:0] DRV_LEFT       = 4'd9;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic               decode_done;
    logic               heartbeat;
    logic [VALUE_W-1:0] y_value;
    logic [VALUE_W-1:0] x_value;
    logic               armed_phase;
    logic               follow_active;
    logic [3:0]         direction_code;
    logic [3:0]         drive_bits;
  } result_t;

endpackage

/* rtl/core/pulse_width_joystick_decoder.sv */
// pulse-width joystick decoder: sample counting, direction decode and output buffering
//
// usage
//   s_axis carries one sample tick per beat, tdata[0] is the received pin level.
//   m_axis returns one result beat for every input beat, in order.
//   cfg_we_i/cfg_index_i/cfg_data_i write the four settings (y centre, x centre,
//   dead zone, follow threshold); write only while no beat is in flight.
// throughput
//   a result is registered at the edge that takes its input beat; one beat per
//   cycle is sustained while the skid register is empty, the counters and the decode
//   compare sit in a single stage between the accepted beat and the result register.
// stall behaviour
//   a two-entry output buffer (result register plus skid register) keeps
//   s_axis_tready_o high while one result waits; it drops only once both hold
//   results the receiver has not taken.
// reset
//   rst_ni clears counters, latches, phase, direction and heartbeat, empties the
//   output buffer and loads the default settings.
module pulse_width_joystick_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwjd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pwjd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pin_level, zero padding
  input  logic [pwjd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // drive_bits, direction_code, follow_active, armed_phase, x_value, y_value,
  // heartbeat, decode_done, zero padding
  output logic [pwjd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pwjd_pkg::*;

  localparam int unsigned CmpW = COUNT_WIDTH + 18;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [CENTER_W-1:0] y_center_q, x_center_q, dead_zone_q;
  logic [THRESH_W-1:0] mode_thr_q;

  logic [COUNT_WIDTH-1:0] high_cnt_q, high_cnt_d, low_cnt_q, low_cnt_d;
  logic [COUNT_WIDTH-1:0] high_inc, low_inc;
  logic [COUNT_WIDTH-1:0] x_latch_q, x_latch_d, y_latch_q, y_latch_d;
  logic                   phase_q, phase_d, toggle_q, toggle_d;
  dir_e                   code_q, code_d;
  logic [3:0]             drive_q, drive_d;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  logic in_fire, out_fire, pin, follow, done;
  logic fwd, back, right, left;
  logic [CmpW-1:0] hc_w, lc_w, yc_w, xc_w, dz_w, thr_w;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;
  assign pin      = s_axis_tdata_i[0];

  always_comb begin
    high_inc = (pin && high_cnt_q != CountMax) ? high_cnt_q + 1'b1 : high_cnt_q;
    low_inc  = (!pin && low_cnt_q != CountMax) ? low_cnt_q + 1'b1 : low_cnt_q;

    hc_w  = CmpW'(high_inc);
    lc_w  = CmpW'(low_inc);
    yc_w  = CmpW'(y_center_q);
    xc_w  = CmpW'(x_center_q);
    dz_w  = CmpW'(dead_zone_q);
    thr_w = CmpW'(mode_thr_q);

    follow = hc_w > thr_w;
    // lower bounds only apply when the dead zone fits below the centre
    fwd   = hc_w > yc_w + dz_w;
    back  = (yc_w >= dz_w) && (hc_w < yc_w - dz_w);
    right = lc_w > xc_w + dz_w;
    left  = (xc_w >= dz_w) && (lc_w < xc_w - dz_w);

    high_cnt_d = high_inc;
    low_cnt_d  = low_inc;
    phase_d    = phase_q;
    x_latch_d  = x_latch_q;
    y_latch_d  = y_latch_q;
    code_d     = code_q;
    drive_d    = drive_q;
    toggle_d   = !toggle_q;
    done       = 1'b0;

    if (!follow) begin
      if (pin && phase_q) begin
        done       = 1'b1;
        x_latch_d  = low_inc;
        high_cnt_d = '0;
        low_cnt_d  = '0;
        phase_d    = 1'b0;
        if (fwd && right) begin
          code_d = DIR_FWD_RIGHT;  drive_d = DRV_FWD_RIGHT;
        end else if (fwd && left) begin
          code_d = DIR_FWD_LEFT;   drive_d = DRV_FWD_LEFT;
        end else if (back && right) begin
          code_d = DIR_BACK_RIGHT; drive_d = DRV_BACK_RIGHT;
        end else if (back && left) begin
          code_d = DIR_BACK_LEFT;  drive_d = DRV_BACK_LEFT;
        end else if (fwd) begin
          code_d = DIR_FWD;        drive_d = DRV_FWD;
        end else if (back) begin
          code_d = DIR_BACK;       drive_d = DRV_BACK;
        end else if (right) begin
          code_d = DIR_RIGHT;      drive_d = DRV_RIGHT;
        end else if (left) begin
          code_d = DIR_LEFT;       drive_d = DRV_LEFT;
        end else begin
          code_d = DIR_STOP;       drive_d = DRV_STOP;
        end
      end else if (!pin && !phase_q) begin
        y_latch_d = high_inc;
        phase_d   = 1'b1;
      end
    end

    res                = '0;
    res.drive_bits     = drive_d;
    res.direction_code = code_d;
    res.follow_active  = follow;
    res.armed_phase    = phase_d;
    res.x_value        = VALUE_W'(x_latch_d);
    res.y_value        = VALUE_W'(y_latch_d);
    res.heartbeat      = toggle_d;
    res.decode_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_center_q  <= Y_CENTER_RST;
      x_center_q  <= X_CENTER_RST;
      dead_zone_q <= DEAD_ZONE_RST;
      mode_thr_q  <= MODE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_Y_CENTER:  y_center_q  <= cfg_data_i[CENTER_W-1:0];
        CFG_X_CENTER:  x_center_q  <= cfg_data_i[CENTER_W-1:0];
        CFG_DEAD_ZONE: dead_zone_q <= cfg_data_i[CENTER_W-1:0];
        CFG_MODE_THR:  mode_thr_q  <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
      phase_q    <= 1'b0;
      x_latch_q  <= '0;
      y_latch_q  <= '0;
      code_q     <= DIR_STOP;
      drive_q    <= DRV_STOP;
      toggle_q   <= 1'b0;
    end else if (in_fire) begin
      high_cnt_q <= high_cnt_d;
      low_cnt_q  <= low_cnt_d;
      phase_q    <= phase_d;
      x_latch_q  <= x_latch_d;
      y_latch_q  <= y_latch_d;
      code_q     <= code_d;
      drive_q    <= drive_d;
      toggle_q   <= toggle_d;
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_q && !m_axis_tready_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !m_axis_tready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while result register is empty");

  a_done_not_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !(done && follow))
    else $error("decode reported on a follow-mode tick");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && done) |=> (phase_q == 1'b0 && high_cnt_q == '0 && low_cnt_q == '0))
    else $error("decode did not clear counters and phase");

  a_heartbeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (toggle_q != $past(toggle_q)))
    else $error("heartbeat did not toggle on an accepted beat");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
